// File: hdl/srdt_pkg.sv
package srdt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int NAME_BYTES  = 16;

  localparam int ADDR_W     = 48;
  localparam int RSSI_W     = 8;
  localparam int LEN_W      = 5;
  localparam int NAME_HW    = 64;
  localparam int IDX_W      = 4;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int OUT_CNT_W  = 5;

  // Filled count runs 0..MAX_ENTRIES; probe position uses the same width.
  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
  // Width in which the read index and a position are compared.
  localparam int CMP_W   = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

  localparam int IN_FIELDS_W  = ADDR_W + RSSI_W + LEN_W + 2 * NAME_HW + IDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = OUT_CNT_W + ADDR_W + RSSI_W + LEN_W + 2 * NAME_HW;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd1;
  localparam int                MODE_READ_BIT = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_NAME_FILLED = 3'd1,
    ST_UNCHANGED   = 3'd2,
    ST_FULL        = 3'd3,
    ST_CLEARED     = 3'd4,
    ST_READ_OK     = 3'd5,
    ST_BEYOND      = 3'd6
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic signed [RSSI_W-1:0] rssi;
    logic [LEN_W-1:0]         len;
    logic [NAME_HW-1:0]       lo;
    logic [NAME_HW-1:0]       hi;
  } entry_t;

  // Item held steady on every cell while a probe walks the row.
  typedef struct packed {
    logic               rd;
    entry_t             ent;
    logic [CMP_W-1:0]   idx;
    logic [COUNT_W-1:0] count;
  } item_t;

  typedef struct packed {
    logic               live;
    logic               done;
    status_e            status;
    logic [COUNT_W-1:0] pos;
    entry_t             data;
  } probe_t;

endpackage

// File: hdl/srdt_cell.sv
module srdt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srdt_pkg::item_t  item_i,
  input  srdt_pkg::probe_t probe_i,
  output srdt_pkg::probe_t probe_o
);
  import srdt_pkg::*;

  entry_t ent_q;
  probe_t probe_q;
  probe_t probe_d;
  logic   wr_all;
  logic   wr_name;

  always_comb begin
    probe_d     = probe_i;
    probe_d.pos = probe_i.pos + 1'b1;
    wr_all      = 1'b0;
    wr_name     = 1'b0;
    if (probe_i.live && !probe_i.done) begin
      if (item_i.rd) begin
        if (CMP_W'(probe_i.pos) == item_i.idx) begin
          probe_d.done   = 1'b1;
          probe_d.status = ST_READ_OK;
          probe_d.data   = ent_q;
        end
      end else if (probe_i.pos < item_i.count) begin
        if (ent_q.addr == item_i.ent.addr) begin
          probe_d.done = 1'b1;
          if ((item_i.ent.len != '0) && (ent_q.len == '0)) begin
            wr_name        = 1'b1;
            probe_d.status = ST_NAME_FILLED;
          end else begin
            probe_d.status = ST_UNCHANGED;
          end
        end
      end else if (probe_i.pos == item_i.count) begin
        // first free slot: append here
        wr_all         = 1'b1;
        probe_d.done   = 1'b1;
        probe_d.status = ST_ADDED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_all) begin
      ent_q <= item_i.ent;
    end else if (wr_name) begin
      ent_q.len <= item_i.ent.len;
      ent_q.lo  <= item_i.ent.lo;
      ent_q.hi  <= item_i.ent.hi;
    end
  end

  assign probe_o = probe_q;

endmodule

// File: hdl/scan_result_dedup_table.sv
// Record and in-range read items: one walk of a probe along the row of MAX_ENTRIES
// cells, one cell per cycle, then S_FINISH and the output register.
// Clear items and reads beyond the count: straight to S_FINISH, then the output register.
// A new item is taken in only in S_IDLE, after the last result is loaded for output;
// a finished result may wait for the sink while the next item is taken in.
// Reset (rst_ni low, asynchronous) empties the table; entry storage is not cleared.
module scan_result_dedup_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tuser: mode [1:0]
  // tdata: device_address, signal_strength, name_length, name_bytes_low,
  //        name_bytes_high, entry_index, zero pad (lowest bit first)
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [srdt_pkg::MODE_W-1:0]         s_axis_tuser,
  input  logic [srdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: status [2:0]
  // tdata: entry_count, read_address, read_strength, read_name_length,
  //        read_name_low, read_name_high, zero pad (lowest bit first)
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [srdt_pkg::STATUS_W-1:0]       m_axis_tuser,
  output logic [srdt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import srdt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_e;

  typedef struct packed {
    status_e status;
    entry_t  data;
  } result_t;

  state_e              state_q;
  logic [COUNT_W-1:0]  count_q;
  logic [COUNT_W-1:0]  count_d;
  logic                launch_q;
  result_t             res_q;
  item_t               item_q;
  item_t               item_d;
  logic                m_tvalid_q;
  logic [STATUS_W-1:0] m_tuser_q;
  logic [OUT_TDATA_W-1:0] m_tdata_q;

  logic                in_xfer;
  logic                load_out;
  logic                walk_start;
  logic [MODE_W-1:0]   in_mode;
  logic [LEN_W-1:0]    in_len;
  logic [LEN_W-1:0]    sat_len;
  logic [2*NAME_HW-1:0] in_name;
  logic [2*NAME_HW-1:0] masked_name;
  logic                idx_in_range;

  probe_t probes [MAX_ENTRIES+1];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == S_FINISH) && (!m_tvalid_q || m_axis_tready);

  // Unpack the input transfer.
  assign in_mode = s_axis_tuser;
  assign in_len  = s_axis_tdata[ADDR_W+RSSI_W +: LEN_W];
  assign in_name = s_axis_tdata[ADDR_W+RSSI_W+LEN_W +: 2*NAME_HW];

  // Saturate an overlong name and zero the bytes past its end.
  always_comb begin
    sat_len = (in_len > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : in_len;
    for (int b = 0; b < 2 * NAME_HW / 8; b++) begin
      masked_name[8*b +: 8] = (LEN_W'(b) < sat_len) ? in_name[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    item_d.rd        = in_mode[MODE_READ_BIT];
    item_d.ent.addr  = s_axis_tdata[0 +: ADDR_W];
    item_d.ent.rssi  = s_axis_tdata[ADDR_W +: RSSI_W];
    item_d.ent.len   = sat_len;
    item_d.ent.lo    = masked_name[0 +: NAME_HW];
    item_d.ent.hi    = masked_name[NAME_HW +: NAME_HW];
    item_d.idx       = CMP_W'(s_axis_tdata[ADDR_W+RSSI_W+LEN_W+2*NAME_HW +: IDX_W]);
    item_d.count     = count_q;
  end

  assign idx_in_range = item_d.idx < CMP_W'(count_q);

  // Records and in-range reads walk the row; clears and reads past the count do not.
  assign walk_start = in_xfer &&
                      (in_mode[MODE_READ_BIT] ? idx_in_range : (in_mode != MODE_CLEAR));

  // Hold the item on the row for the whole walk.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
  end

  // Inject the probe at the head of the row; it starts out as a full-table miss.
  assign probes[0] = '{live: launch_q, done: 1'b0, status: ST_FULL, pos: '0, data: '0};

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    srdt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .item_i  (item_q),
      .probe_i (probes[k]),
      .probe_o (probes[k+1])
    );
  end

  // Count after this item: a clear empties the table, an append grows it.
  always_comb begin
    unique case (res_q.status)
      ST_CLEARED: count_d = '0;
      ST_ADDED:   count_d = count_q + 1'b1;
      default:    count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      launch_q   <= 1'b0;
      res_q      <= '0;
      m_tvalid_q <= 1'b0;
      m_tuser_q  <= '0;
      m_tdata_q  <= '0;
    end else begin
      launch_q <= walk_start;
      // Raise tvalid on a new result, drop it once the sink has taken the old one.
      if (load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tvalid_q && m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            res_q.data <= '0;
            if (in_mode[MODE_READ_BIT]) begin
              if (idx_in_range) begin
                state_q  <= S_WALK;
              end else begin
                res_q.status <= ST_BEYOND;
                state_q      <= S_FINISH;
              end
            end else if (in_mode == MODE_CLEAR) begin
              res_q.status <= ST_CLEARED;
              state_q      <= S_FINISH;
            end else begin
              state_q  <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // Take the probe as it leaves the last cell.
          if (probes[MAX_ENTRIES].live) begin
            res_q.status <= probes[MAX_ENTRIES].status;
            res_q.data   <= probes[MAX_ENTRIES].data;
            state_q      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            count_q    <= count_d;
            m_tuser_q  <= res_q.status;
            m_tdata_q  <= {{OUT_PAD_W{1'b0}}, res_q.data.hi, res_q.data.lo,
                           res_q.data.len, res_q.data.rssi, res_q.data.addr,
                           OUT_CNT_W'(count_d)};
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tuser  = m_tuser_q;
  assign m_axis_tdata  = m_tdata_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(MAX_ENTRIES))
    else $error("filled count beyond table size");

  a_probe_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probes[MAX_ENTRIES].live |-> (state_q == S_WALK))
    else $error("probe left the row outside a walk");

  a_launch_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> (state_q == S_WALK))
    else $error("probe launched outside a walk");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (res_q.status == ST_ADDED)) |=> (count_q == $past(count_q) + 1'b1))
    else $error("append did not grow the count");
`endif

endmodule
